FILE: rtl/a2i_pkg.sv
// a2i_pkg: shared types, character constants and the character classifier
// for the ASCII to int64 parser. No dependencies.

package a2i_pkg;

   // Field widths
   localparam int CHAR_WIDTH  = 8;
   localparam int RADIX_WIDTH = 6;
   localparam int VALUE_WIDTH = 64;
   localparam int INDEX_WIDTH = 16;

   // Request queue between front and back
   localparam int QUEUE_DEPTH = 2;

   // Character codes
   localparam logic [CHAR_WIDTH-1:0] CHAR_SPACE  = 8'h20;
   localparam logic [CHAR_WIDTH-1:0] CHAR_MINUS  = 8'h2D;
   localparam logic [CHAR_WIDTH-1:0] CHAR_PLUS   = 8'h2B;
   localparam logic [CHAR_WIDTH-1:0] CHAR_ZERO   = 8'h30;
   localparam logic [CHAR_WIDTH-1:0] CHAR_NINE   = 8'h39;
   localparam logic [CHAR_WIDTH-1:0] CHAR_LOW_X  = 8'h78;
   localparam logic [CHAR_WIDTH-1:0] CHAR_UP_X   = 8'h58;
   localparam logic [CHAR_WIDTH-1:0] CHAR_LOW_A  = 8'h61;
   localparam logic [CHAR_WIDTH-1:0] CHAR_LOW_Z  = 8'h7A;
   localparam logic [CHAR_WIDTH-1:0] CHAR_UP_A   = 8'h41;
   localparam logic [CHAR_WIDTH-1:0] CHAR_UP_Z   = 8'h5A;
   localparam logic [CHAR_WIDTH-1:0] LOW_LETTER_BIAS = 8'h57;  // 'a' - 10
   localparam logic [CHAR_WIDTH-1:0] UP_LETTER_BIAS  = 8'h37;  // 'A' - 10

   // Fixed radices picked by the prefix logic
   localparam logic [RADIX_WIDTH-1:0] RADIX_AUTO = 6'd0;
   localparam logic [RADIX_WIDTH-1:0] RADIX_OCT  = 6'd8;
   localparam logic [RADIX_WIDTH-1:0] RADIX_DEC  = 6'd10;
   localparam logic [RADIX_WIDTH-1:0] RADIX_HEX  = 6'd16;

   // One classified request as it sits in the queue
   typedef struct packed {
      logic                   start;
      logic                   digit_ok;
      logic [RADIX_WIDTH-1:0] digit_val;
      logic                   is_space;
      logic                   is_minus;
      logic                   is_plus;
      logic                   is_x;
   } char_class_type;

   // Decode one character into its class bits
   function automatic char_class_type classify(input logic [CHAR_WIDTH-1:0] c,
                                               input logic start);
      char_class_type         cls;
      logic [CHAR_WIDTH-1:0]  dv;
      cls.start    = start;
      cls.is_space = (c == CHAR_SPACE);
      cls.is_minus = (c == CHAR_MINUS);
      cls.is_plus  = (c == CHAR_PLUS);
      cls.is_x     = (c == CHAR_LOW_X) || (c == CHAR_UP_X);
      dv           = '0;
      cls.digit_ok = 1'b1;
      if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
         dv = c - CHAR_ZERO;
      end else if (c >= CHAR_LOW_A && c <= CHAR_LOW_Z) begin
         dv = c - LOW_LETTER_BIAS;
      end else if (c >= CHAR_UP_A && c <= CHAR_UP_Z) begin
         dv = c - UP_LETTER_BIAS;
      end else begin
         cls.digit_ok = 1'b0;
      end
      cls.digit_val = dv[RADIX_WIDTH-1:0];
      return cls;
   endfunction

endpackage

FILE: rtl/a2i_front.sv
// a2i_front: accepts characters, classifies them and holds them in a short
// request queue for the parse engine. Depends on a2i_pkg.

module a2i_front (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [a2i_pkg::CHAR_WIDTH-1:0]       req_char_byte,
   input  logic                                 req_string_start,
   output logic                                 q_valid,
   output a2i_pkg::char_class_type              q_entry,
   input  logic                                 q_pop
);

   localparam int PTR_W = (a2i_pkg::QUEUE_DEPTH > 1) ? $clog2(a2i_pkg::QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(a2i_pkg::QUEUE_DEPTH + 1);
   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(a2i_pkg::QUEUE_DEPTH);

   a2i_pkg::char_class_type q_mem_ff [a2i_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push;
   logic             pop;

   // Queue full stalls the sender; no path from the back's stall
   assign req_stall = (count_ff == DEPTH_CNT);
   assign push      = req_valid && !req_stall;
   assign q_valid   = (count_ff != '0);
   assign pop       = q_pop && q_valid;
   assign q_entry   = q_mem_ff[rd_ptr_ff];

   // Pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(a2i_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                   : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(a2i_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                   : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue storage, classified on the way in
   always_ff @(posedge clock) begin
      if (push) begin
         q_mem_ff[wr_ptr_ff] <= a2i_pkg::classify(req_char_byte, req_string_start);
      end
   end

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= DEPTH_CNT)
      else $error("request queue count over depth");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |=> ($past(count_in) == count_ff))
      else $error("request queue count update lost");

   a_full_holds: assert property (@(posedge clock) disable iff (reset)
      (req_stall && !q_pop) |=> (req_stall && $stable(rd_ptr_ff)))
      else $error("full queue drained without a pop");
`endif

endmodule

FILE: rtl/a2i_back.sv
// a2i_back: parse engine. Runs the sign / prefix / digit state machine on
// classified requests, accumulates the value and holds the result register.
// Depends on a2i_pkg.

module a2i_back #(
   parameter int POSITION_WIDTH = 16
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic [a2i_pkg::RADIX_WIDTH-1:0]         radix_select,
   input  logic                                    q_valid,
   input  a2i_pkg::char_class_type                 q_entry,
   output logic                                    q_pop,
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output logic signed [a2i_pkg::VALUE_WIDTH-1:0]  rsp_parsed_value,
   output logic [a2i_pkg::INDEX_WIDTH-1:0]         rsp_end_index,
   output logic                                    rsp_digits_found
);

   localparam int EXT_W = (POSITION_WIDTH > a2i_pkg::INDEX_WIDTH) ? POSITION_WIDTH
                                                                  : a2i_pkg::INDEX_WIDTH;
   localparam logic [POSITION_WIDTH-1:0] POS_MAX = '1;

   // Parse phases
   localparam logic [2:0] PH_IDLE   = 3'd0;
   localparam logic [2:0] PH_LEAD   = 3'd1;
   localparam logic [2:0] PH_SIGNED = 3'd2;
   localparam logic [2:0] PH_ZERO   = 3'd3;
   localparam logic [2:0] PH_DIGITS = 3'd4;

   logic [2:0]                        phase_ff, phase_in;
   logic                              minus_ff, minus_in;
   logic [a2i_pkg::RADIX_WIDTH-1:0]   radix_ff, radix_in;
   logic [a2i_pkg::VALUE_WIDTH-1:0]   acc_ff, acc_in;
   logic [POSITION_WIDTH-1:0]         pos_ff, pos_in;
   logic                              any_ff, any_in;

   logic                              rsp_valid_ff;
   logic [a2i_pkg::VALUE_WIDTH-1:0]   rsp_value_ff, rsp_value_in;
   logic [a2i_pkg::INDEX_WIDTH-1:0]   rsp_index_ff, rsp_index_in;
   logic                              rsp_digits_ff;

   // Working copies after the start / position step
   logic [2:0]                        ph_b;
   logic                              minus_b;
   logic [a2i_pkg::RADIX_WIDTH-1:0]   radix_b;
   logic [a2i_pkg::VALUE_WIDTH-1:0]   acc_b;
   logic [POSITION_WIDTH-1:0]         pos_b;
   logic                              any_b;

   logic                              first;
   logic                              take;
   logic                              emit;
   logic [a2i_pkg::RADIX_WIDTH-1:0]   r;
   logic [a2i_pkg::VALUE_WIDTH-1:0]   a;
   logic [EXT_W-1:0]                  pos_ext;

   // Take the next request whenever the result register is free or draining
   assign q_pop = q_valid && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      // start of string resets the parse, otherwise count the position
      ph_b    = phase_ff;
      minus_b = minus_ff;
      radix_b = radix_ff;
      acc_b   = acc_ff;
      pos_b   = pos_ff;
      any_b   = any_ff;
      if (q_entry.start) begin
         ph_b    = PH_LEAD;
         minus_b = 1'b0;
         radix_b = radix_select;
         acc_b   = '0;
         pos_b   = '0;
         any_b   = 1'b0;
      end else if (phase_ff != PH_IDLE && pos_ff != POS_MAX) begin
         pos_b = pos_ff + 1'b1;
      end

      phase_in = ph_b;
      minus_in = minus_b;
      radix_in = radix_b;
      acc_in   = acc_b;
      pos_in   = pos_b;
      any_in   = any_b;
      first    = 1'b0;
      take     = 1'b0;
      emit     = 1'b0;
      r        = radix_b;
      a        = acc_b;

      // phase step
      unique case (ph_b)
         PH_LEAD: begin
            priority if (q_entry.is_space) begin
               phase_in = PH_LEAD;
            end else if (q_entry.is_minus) begin
               minus_in = 1'b1;
               phase_in = PH_SIGNED;
            end else if (q_entry.is_plus) begin
               phase_in = PH_SIGNED;
            end else begin
               first = 1'b1;
            end
         end
         PH_SIGNED: begin
            first = 1'b1;
         end
         PH_ZERO: begin
            phase_in = PH_DIGITS;
            if (q_entry.is_x) begin
               radix_in = a2i_pkg::RADIX_HEX;
            end else begin
               any_in = 1'b1;
               a      = '0;
               if (r == a2i_pkg::RADIX_AUTO) begin
                  r = a2i_pkg::RADIX_OCT;
               end
               take = 1'b1;
            end
         end
         PH_DIGITS: begin
            take = 1'b1;
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase

      // first character after spaces and sign: prefix detection
      if (first) begin
         if ((r == a2i_pkg::RADIX_AUTO || r == a2i_pkg::RADIX_HEX) && q_entry.digit_ok &&
             q_entry.digit_val == '0) begin
            phase_in = PH_ZERO;
         end else begin
            if (r == a2i_pkg::RADIX_AUTO) begin
               r = a2i_pkg::RADIX_DEC;
            end
            phase_in = PH_DIGITS;
            take     = 1'b1;
         end
      end

      // digit accumulate or terminate
      if (take) begin
         radix_in = r;
         if (q_entry.digit_ok && q_entry.digit_val < r) begin
            acc_in = a2i_pkg::VALUE_WIDTH'(a * a2i_pkg::VALUE_WIDTH'(r)) +
                     a2i_pkg::VALUE_WIDTH'(q_entry.digit_val);
            any_in = 1'b1;
         end else begin
            acc_in   = a;
            emit     = 1'b1;
            phase_in = PH_IDLE;
         end
      end

      // idle characters that do not start a string change nothing
      if (!q_entry.start && phase_ff == PH_IDLE) begin
         phase_in = phase_ff;
         minus_in = minus_ff;
         radix_in = radix_ff;
         acc_in   = acc_ff;
         pos_in   = pos_ff;
         any_in   = any_ff;
         emit     = 1'b0;
      end
   end

   // Result fields
   assign pos_ext      = EXT_W'(pos_b);
   assign rsp_value_in = minus_b ? (a2i_pkg::VALUE_WIDTH'(0) - a) : a;
   assign rsp_index_in = any_in ? pos_ext[a2i_pkg::INDEX_WIDTH-1:0] : '0;

   // Parse state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         minus_ff <= 1'b0;
         radix_ff <= '0;
         acc_ff   <= '0;
         pos_ff   <= '0;
         any_ff   <= 1'b0;
      end else if (q_pop) begin
         phase_ff <= phase_in;
         minus_ff <= minus_in;
         radix_ff <= radix_in;
         acc_ff   <= acc_in;
         pos_ff   <= pos_in;
         any_ff   <= any_in;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (q_pop) begin
         rsp_valid_ff <= emit;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop && emit) begin
         rsp_value_ff  <= rsp_value_in;
         rsp_index_ff  <= rsp_index_in;
         rsp_digits_ff <= any_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_parsed_value = rsp_value_ff;
   assign rsp_end_index    = rsp_index_ff;
   assign rsp_digits_found = rsp_digits_ff;

`ifndef SYNTHESIS
   a_emit_shows: assert property (@(posedge clock) disable iff (reset)
      (q_pop && emit) |=> rsp_valid_ff)
      else $error("terminated parse did not raise a response");

   a_no_digit_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_digits_ff) |-> (rsp_index_ff == '0 && rsp_value_ff == '0))
      else $error("digitless response carries value or index");

   a_acc_needs_digit: assert property (@(posedge clock) disable iff (reset)
      !any_ff |-> (acc_ff == '0))
      else $error("accumulator nonzero before any digit");

   a_zero_phase_clean: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_ZERO) |-> (!any_ff && acc_ff == '0))
      else $error("leading zero phase with digits taken");
`endif

endmodule

FILE: rtl/ascii_to_int64_parser.sv
// ascii_to_int64_parser: top level of the streaming strtol-style parser.
// Depends on a2i_pkg, a2i_front and a2i_back.
//
// Usage:
//   Request channel (req_valid / req_stall) carries one character per
//   request with req_string_start marking the first character of a string.
//   Response channel (rsp_valid / rsp_stall) carries one result per parsed
//   string, produced on its terminating character: value, end index and a
//   digits-found flag. Strings that never terminate give no response.
//   csr_wr_en / csr_wr_data write the base (0 = detect from prefix); it is
//   latched at each string start, so write it only while the block is idle.
// Throughput: one character per cycle while rsp_stall does not hold the
//   result register, set by the single multiply-add of the accumulator by
//   the base in the parse engine.
// Path: the request queue, then the result register holds the response.
// Stalls: rsp_stall holds the result register; the 2-entry request queue
//   then fills and req_stall rises. req_stall depends only on the queue fill.
// Reset: synchronous, active high; clears the queue, the parse state, the
//   base register (to 0) and the response valid. No clearing pass.

module ascii_to_int64_parser #(
   parameter int POSITION_WIDTH = 16
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_stall,
   input  logic [a2i_pkg::CHAR_WIDTH-1:0]          req_char_byte,
   input  logic                                    req_string_start,
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output logic signed [a2i_pkg::VALUE_WIDTH-1:0]  rsp_parsed_value,
   output logic [a2i_pkg::INDEX_WIDTH-1:0]         rsp_end_index,
   output logic                                    rsp_digits_found,
   input  logic                                    csr_wr_en,
   input  logic [a2i_pkg::RADIX_WIDTH-1:0]         csr_wr_data
);

   logic [a2i_pkg::RADIX_WIDTH-1:0] radix_select_ff;
   logic                            q_valid;
   logic                            q_pop;
   a2i_pkg::char_class_type         q_entry;

   // Base register
   always_ff @(posedge clock) begin
      if (reset) begin
         radix_select_ff <= '0;
      end else if (csr_wr_en) begin
         radix_select_ff <= csr_wr_data;
      end
   end

   a2i_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_char_byte    (req_char_byte),
      .req_string_start (req_string_start),
      .q_valid          (q_valid),
      .q_entry          (q_entry),
      .q_pop            (q_pop)
   );

   a2i_back #(
      .POSITION_WIDTH (POSITION_WIDTH)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .radix_select     (radix_select_ff),
      .q_valid          (q_valid),
      .q_entry          (q_entry),
      .q_pop            (q_pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_parsed_value (rsp_parsed_value),
      .rsp_end_index    (rsp_end_index),
      .rsp_digits_found (rsp_digits_found)
   );

endmodule

FILE: bench/parse_tb_pkg.sv
`timescale 1ns / 100ps
// parse_tb_pkg: expected-result tracker for the ASCII to int64 parser bench.
// Depends on a2i_pkg for field widths, character codes and fixed radices.

package parse_tb_pkg;
   import a2i_pkg::*;

   localparam int POSITION_WIDTH = 16;
   localparam int NOT_DIGIT      = 255;

   typedef enum logic [2:0] {
      PHASE_IDLE,
      PHASE_LEAD,
      PHASE_SIGNED,
      PHASE_ZERO,
      PHASE_DIGITS
   } parse_phase_t;

   // One parsed number as it should leave the response channel
   typedef struct packed {
      logic signed [VALUE_WIDTH-1:0] value;
      logic [INDEX_WIDTH-1:0]        index;
      logic                          found;
   } parse_result_t;

   // Weight of a digit or letter, NOT_DIGIT for anything else
   function automatic int digit_weight(input logic [CHAR_WIDTH-1:0] c);
      if (c >= CHAR_ZERO && c <= CHAR_NINE) return int'(c - CHAR_ZERO);
      if (c >= CHAR_LOW_A && c <= CHAR_LOW_Z) return int'(c - LOW_LETTER_BIAS);
      if (c >= CHAR_UP_A && c <= CHAR_UP_Z) return int'(c - UP_LETTER_BIAS);
      return NOT_DIGIT;
   endfunction

   class parse_tracker;
      bit [RADIX_WIDTH-1:0]    radix_reg;
      bit [RADIX_WIDTH-1:0]    radix_now;
      parse_phase_t            phase;
      bit                      minus;
      bit                      any_digit;
      bit [VALUE_WIDTH-1:0]    acc;
      bit [POSITION_WIDTH-1:0] pos;
      parse_result_t           results_due[$];
      int                      errors;

      function new();
         radix_reg = RADIX_AUTO;
         radix_now = RADIX_AUTO;
         phase     = PHASE_IDLE;
         minus     = 1'b0;
         any_digit = 1'b0;
         acc       = '0;
         pos       = '0;
         errors    = 0;
      endfunction

      function void set_radix(input bit [RADIX_WIDTH-1:0] v);
         radix_reg = v;
      endfunction

      function int outstanding();
         return results_due.size();
      endfunction

      // Accumulate a digit, or close the parse on anything else
      function void take_digit(input logic [CHAR_WIDTH-1:0] c);
         int            d;
         parse_result_t r;
         d = digit_weight(c);
         if (d < int'(radix_now)) begin
            acc       = acc * VALUE_WIDTH'(radix_now) + VALUE_WIDTH'(d);
            any_digit = 1'b1;
         end else begin
            r.value = minus ? -acc : acc;
            r.index = any_digit ? pos[INDEX_WIDTH-1:0] : '0;
            r.found = any_digit;
            results_due.push_back(r);
            phase = PHASE_IDLE;
         end
      endfunction

      // First character after spaces or sign: a zero may open a prefix
      function void take_first(input logic [CHAR_WIDTH-1:0] c);
         if ((radix_now == RADIX_AUTO || radix_now == RADIX_HEX) && c == CHAR_ZERO) begin
            phase = PHASE_ZERO;
         end else begin
            if (radix_now == RADIX_AUTO) radix_now = RADIX_DEC;
            phase = PHASE_DIGITS;
            take_digit(c);
         end
      endfunction

      // Accepted request on the character channel
      function void note_char(input logic [CHAR_WIDTH-1:0] c, input logic first);
         if (first) begin
            phase     = PHASE_LEAD;
            minus     = 1'b0;
            radix_now = radix_reg;
            acc       = '0;
            pos       = '0;
            any_digit = 1'b0;
         end else begin
            if (phase == PHASE_IDLE) return;
            if (pos != '1) pos++;
         end
         case (phase)
            PHASE_LEAD: begin
               if (c == CHAR_MINUS) begin
                  minus = 1'b1;
                  phase = PHASE_SIGNED;
               end else if (c == CHAR_PLUS) begin
                  phase = PHASE_SIGNED;
               end else if (c != CHAR_SPACE) begin
                  take_first(c);
               end
            end
            PHASE_SIGNED: take_first(c);
            PHASE_ZERO: begin
               phase = PHASE_DIGITS;
               if (c == CHAR_LOW_X || c == CHAR_UP_X) begin
                  radix_now = RADIX_HEX;
               end else begin
                  any_digit = 1'b1;
                  acc       = '0;
                  if (radix_now == RADIX_AUTO) radix_now = RADIX_OCT;
                  take_digit(c);
               end
            end
            PHASE_DIGITS: take_digit(c);
            default: phase = PHASE_IDLE;
         endcase
      endfunction

      // Response accepted: compare with the oldest parse still due
      function void check_result(input logic signed [VALUE_WIDTH-1:0] value,
                                 input logic [INDEX_WIDTH-1:0] index,
                                 input logic found);
         parse_result_t want;
         if (results_due.size() == 0) begin
            $display("%0t: unexpected response, expected none, got value %0d index %0d found %0b",
                     $time, value, index, found);
            errors++;
            return;
         end
         want = results_due.pop_front();
         if (value !== want.value) begin
            $display("%0t: parsed value expected %0d got %0d", $time, want.value, value);
            errors++;
         end
         if (index !== want.index) begin
            $display("%0t: end index expected %0d got %0d", $time, want.index, index);
            errors++;
         end
         if (found !== want.found) begin
            $display("%0t: digits found expected %0b got %0b", $time, want.found, found);
            errors++;
         end
      endfunction
   endclass

endpackage

FILE: bench/testbench.sv
`timescale 1ns / 100ps
// testbench: streams strings into ascii_to_int64_parser and checks every parse
// against parse_tb_pkg::parse_tracker. Depends on a2i_pkg and parse_tb_pkg.

module testbench;
   import a2i_pkg::*;
   import parse_tb_pkg::*;

   typedef struct packed {
      logic [CHAR_WIDTH-1:0] ch;
      logic                  first;
   } char_req_type;

   logic                          clock;
   logic                          reset;
   logic                          req_valid;
   logic                          req_stall;
   logic [CHAR_WIDTH-1:0]         req_char_byte;
   logic                          req_string_start;
   logic                          rsp_valid;
   logic                          rsp_stall;
   logic signed [VALUE_WIDTH-1:0] rsp_parsed_value;
   logic [INDEX_WIDTH-1:0]        rsp_end_index;
   logic                          rsp_digits_found;
   logic                          csr_wr_en;
   logic [RADIX_WIDTH-1:0]        csr_wr_data;

   parse_tracker tracker = new();
   char_req_type stream_q[$];
   bit           fresh;
   int           send_idle;
   int           recv_stall;

   ascii_to_int64_parser u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_char_byte    (req_char_byte),
      .req_string_start (req_string_start),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_parsed_value (rsp_parsed_value),
      .rsp_end_index    (rsp_end_index),
      .rsp_digits_found (rsp_digits_found),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Run limit, well beyond the slowest legal run
   initial begin
      #20_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

   // Receiver back-pressure
   always @(negedge clock) begin
      rsp_stall <= (recv_stall != 0) && ($urandom_range(99) < recv_stall);
   end

   // Observe both handshakes at the rising edge
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) tracker.note_char(req_char_byte, req_string_start);
         if (rsp_valid && !rsp_stall)
            tracker.check_result(rsp_parsed_value, rsp_end_index, rsp_digits_found);
      end
   end

   // Stream building
   function automatic void push_raw(input logic [CHAR_WIDTH-1:0] c, input logic s);
      char_req_type r;
      r.ch    = c;
      r.first = s;
      stream_q.push_back(r);
   endfunction

   function automatic void push_piece(input logic [CHAR_WIDTH-1:0] c);
      push_raw(c, fresh);
      fresh = 1'b0;
   endfunction

   function automatic void push_text(input string s);
      int i;
      fresh = 1'b1;
      for (i = 0; i < s.len(); i++) push_piece(s[i]);
   endfunction

   function automatic logic [CHAR_WIDTH-1:0] digit_char(input int v);
      if (v < 10) return CHAR_ZERO + CHAR_WIDTH'(v);
      return ($urandom_range(1) ? CHAR_LOW_A : CHAR_UP_A) + CHAR_WIDTH'(v - 10);
   endfunction

   // Any byte that is not a digit below lim
   function automatic logic [CHAR_WIDTH-1:0] stop_char(input int lim);
      logic [CHAR_WIDTH-1:0] c;
      c = CHAR_WIDTH'($urandom_range(255));
      while (digit_weight(c) < lim) c = CHAR_WIDTH'($urandom_range(255));
      return c;
   endfunction

   // Well-formed number: spaces, sign, prefix, digits, optional terminator
   function automatic void push_number(input int base_reg, input bit terminate);
      int base_eff;
      int lim;
      int n;
      int k;
      int pick;
      fresh = 1'b1;
      n = ($urandom_range(3) == 0) ? $urandom_range(1, 3) : 0;
      for (k = 0; k < n; k++) push_piece(CHAR_SPACE);
      pick = $urandom_range(3);
      if (pick == 1) push_piece(CHAR_MINUS);
      else if (pick == 2) push_piece(CHAR_PLUS);
      base_eff = base_reg;
      if (base_reg == RADIX_AUTO || base_reg == RADIX_HEX) begin
         pick = $urandom_range(2);
         if (pick == 0) begin
            push_piece(CHAR_ZERO);
            push_piece($urandom_range(1) ? CHAR_LOW_X : CHAR_UP_X);
            base_eff = RADIX_HEX;
         end else if (base_reg == RADIX_AUTO && pick == 1) begin
            push_piece(CHAR_ZERO);
            base_eff = RADIX_OCT;
         end else if (base_reg == RADIX_AUTO) begin
            base_eff = RADIX_DEC;
         end
      end
      lim = (base_eff > 36) ? 36 : base_eff;
      n = $urandom_range(1, $urandom_range(1) ? 4 : 24);
      for (k = 0; k < n; k++) push_piece(digit_char($urandom_range(lim - 1)));
      if (terminate) push_piece(stop_char(lim));
   endfunction

   // Mostly numbers, the rest noise and broken strings
   function automatic void build_phase(input int base_reg, input int goal);
      int pick;
      int n;
      int k;
      while (stream_q.size() < goal) begin
         pick = $urandom_range(99);
         if (pick < 72) begin
            push_number(base_reg, 1'b1);
         end else if (pick < 80) begin
            // no terminator: a later string start abandons it unless noise ends it
            push_number(base_reg, 1'b0);
         end else if (pick < 86) begin
            n = $urandom_range(1, 6);
            for (k = 0; k < n; k++)
               push_raw(CHAR_WIDTH'($urandom_range(255)), $urandom_range(3) == 0);
         end else if (pick < 90) begin
            n = $urandom_range(1, 3);
            for (k = 0; k < n; k++) push_raw(CHAR_WIDTH'($urandom_range(255)), 1'b0);
         end else if (pick < 95) begin
            // sign followed by a space ends the parse
            fresh = 1'b1;
            push_piece($urandom_range(1) ? CHAR_MINUS : CHAR_PLUS);
            push_piece(CHAR_SPACE);
         end else begin
            // hex prefix with no hex digit after it
            fresh = 1'b1;
            push_piece(CHAR_ZERO);
            push_piece($urandom_range(1) ? CHAR_LOW_X : CHAR_UP_X);
            push_piece(stop_char(16));
         end
      end
      push_number(base_reg, 1'b1);
   endfunction

   // Driving tasks, entered just after a falling edge
   task automatic send_char(input logic [CHAR_WIDTH-1:0] c, input logic s);
      while (send_idle != 0 && $urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_char_byte    <= c;
      req_string_start <= s;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic wait_results();
      req_valid <= 1'b0;
      @(negedge clock);
      while (tracker.outstanding() != 0) @(negedge clock);
   endtask

   task automatic send_stream();
      int i;
      for (i = 0; i < stream_q.size(); i++) begin
         // now and then hold off until the block has caught up
         if (stream_q[i].first && $urandom_range(40) == 0) wait_results();
         send_char(stream_q[i].ch, stream_q[i].first);
      end
      stream_q.delete();
   endtask

   // Idle: nothing due, plus extra waiting for requests that give no response
   task automatic settle();
      wait_results();
      repeat (6) @(negedge clock);
   endtask

   task automatic write_radix(input logic [RADIX_WIDTH-1:0] v);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      tracker.set_radix(v);
      @(negedge clock);
   endtask

   initial begin
      logic [RADIX_WIDTH-1:0] radix_plan[8];
      logic [RADIX_WIDTH-1:0] base;
      int p;
      int k;
      radix_plan = '{RADIX_AUTO, RADIX_DEC, RADIX_HEX, RADIX_OCT,
                     6'd2, 6'd1, 6'd36, 6'd63};
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_char_byte    = '0;
      req_string_start = 1'b0;
      rsp_stall        = 1'b0;
      csr_wr_en        = 1'b0;
      csr_wr_data      = '0;
      send_idle        = 0;
      recv_stall       = 0;
      fresh            = 1'b0;
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: prefixes, signs, restart, idle characters, byte extremes
      write_radix(RADIX_AUTO);
      push_raw(8'h00, 1'b0);
      push_text("  -0x1F;");
      push_text("0x%");
      push_text("+ 5");
      push_text("-077");
      push_raw(8'hFF, 1'b0);
      push_text("123");
      push_text("4#");
      send_stream();
      settle();

      // Random phases over the base settings and idling patterns
      for (p = 0; p < 12; p++) begin
         base = (p < 8) ? radix_plan[p] : RADIX_WIDTH'($urandom_range(63));
         write_radix(base);
         unique case (p % 4)
            0: begin send_idle = 0;  recv_stall = 0;  end
            1: begin send_idle = 75; recv_stall = 0;  end
            2: begin send_idle = 0;  recv_stall = 75; end
            default: begin send_idle = 23; recv_stall = 23; end
         endcase
         build_phase(base, 100);
         send_stream();
         settle();
      end

      // One long decimal string, wrapping the accumulator many times
      write_radix(RADIX_DEC);
      send_idle  = 0;
      recv_stall = 0;
      fresh      = 1'b1;
      push_piece(CHAR_ZERO + 8'd7);
      for (k = 0; k < 60; k++) push_piece(digit_char($urandom_range(9)));
      push_piece(CHAR_PLUS);
      send_stream();
      settle();

      repeat (10) @(negedge clock);
      if (tracker.errors == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
